[sv/sme_pkg.sv]
// ----------------------------------------------------------------------------
// sme_pkg: shared types and constants for the moving average core
// Item structs, controller state, command and status bundles.
// ----------------------------------------------------------------------------
package sme_pkg;

	localparam int SAMPLE_W   = 32;
	localparam int PERIOD_W   = 9;
	localparam int WEIGHT_W   = 17;
	localparam int FRAC_W     = 16;
	localparam int EXP_W      = SAMPLE_W + FRAC_W;
	localparam int DIVR_W     = PERIOD_W + 1;
	localparam int DEF_PERIOD = 20;
	// 2.0 in Q2.16
	localparam int WEIGHT_NUM = 131072;

	typedef struct packed {
		logic [SAMPLE_W-1:0] price;
		logic                series_start;
	} sme_in_t;

	typedef struct packed {
		logic [SAMPLE_W-1:0] window_mean;
		logic                mean_ready;
		logic [SAMPLE_W-1:0] exp_mean;
	} sme_out_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WGT_GO,
		ST_WGT_WAIT,
		ST_PREP,
		ST_UPD,
		ST_EMA,
		ST_DIV_WAIT,
		ST_DONE
	} sme_state_t;

	typedef struct packed {
		logic load;
		logic wgt_start;
		logic wgt_load;
		logic prep;
		logic upd;
		logic ema;
		logic out_load;
	} sme_cmd_t;

	typedef struct packed {
		logic wgt_stale;
		logic div_done;
	} sme_sts_t;

endpackage

[sv/sme_div.sv]
// ----------------------------------------------------------------------------
// sme_div: iterative restoring divider
// One quotient bit per cycle; pulses done when the quotient is complete.
// ----------------------------------------------------------------------------
module sme_div
	import sme_pkg::*;
#(
	parameter int DIVD_W = 40
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVR_W-1:0] divisor,
	output logic [DIVD_W-1:0] quotient,
	output logic              done
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic              busy_q;
	logic              done_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [DIVR_W-1:0] dvsr_q;
	logic [DIVR_W-1:0] rem_q;
	logic [DIVD_W-1:0] quo_q;
	logic [DIVR_W:0]   trial;
	logic              fits;

	assign trial = {rem_q, quo_q[DIVD_W-1]};
	assign fits  = trial >= {1'b0, dvsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvsr_q <= divisor;
			rem_q  <= '0;
			quo_q  <= dividend;
		end else if (busy_q) begin
			rem_q <= fits ? DIVR_W'(trial - {1'b0, dvsr_q}) : trial[DIVR_W-1:0];
			quo_q <= {quo_q[DIVD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

[sv/sme_dp.sv]
// ----------------------------------------------------------------------------
// sme_dp: moving average datapath
// Sample ring, window sum, exponential state, weight and result register.
// ----------------------------------------------------------------------------
module sme_dp
	import sme_pkg::*;
#(
	parameter int MAX_PERIOD = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [PERIOD_W-1:0] cfg_wr_data,
	input  sme_in_t             sample,
	input  sme_cmd_t            cmd,
	output sme_sts_t            sts,
	output sme_out_t            result
);

	localparam int PTR_W        = $clog2(MAX_PERIOD);
	localparam int SUM_W        = SAMPLE_W + PTR_W;
	localparam int CMP_W        = (PTR_W + 1 > PERIOD_W) ? PTR_W + 1 : PERIOD_W;
	localparam int PERIOD_MAXV  = (1 << PERIOD_W) - 1;
	localparam int PERIOD_CAP   = (MAX_PERIOD > PERIOD_MAXV) ? PERIOD_MAXV : MAX_PERIOD;
	localparam int RESET_PERIOD = (MAX_PERIOD < DEF_PERIOD) ? MAX_PERIOD : DEF_PERIOD;
	localparam int RESET_WEIGHT = WEIGHT_NUM / (RESET_PERIOD + 1);
	localparam int PH_W         = SAMPLE_W + WEIGHT_W;
	localparam int PL_W         = FRAC_W + WEIGHT_W;
	localparam int Q_W          = PH_W + 1;

	logic [SAMPLE_W-1:0] ring_mem [MAX_PERIOD];

	logic [PERIOD_W-1:0] n_q;
	logic [WEIGHT_W-1:0] w_q;
	logic                stale_q;
	logic [SUM_W-1:0]    sum_q;
	logic [PERIOD_W-1:0] seen_q;
	logic [PTR_W-1:0]    ptr_q;
	logic [EXP_W-1:0]    exp_q;

	logic [SAMPLE_W-1:0] price_q;
	logic                start_q;
	logic [SAMPLE_W-1:0] old_q;
	logic [EXP_W-1:0]    d_q;
	logic                neg_q;
	logic [PH_W-1:0]     ph_q;
	logic [PL_W-1:0]     pl_q;
	logic                ready_q;
	sme_out_t            result_q;

	logic [PERIOD_W-1:0] cfg_n;
	logic [PTR_W-1:0]    rd_ptr;
	logic                full;
	logic [SUM_W-1:0]    sum_next;
	logic [PERIOD_W-1:0] seen_next;
	logic [CMP_W-1:0]    ptr_inc;
	logic                wrap;
	logic [EXP_W-1:0]    x;
	logic [Q_W-1:0]      q;
	logic                rem;
	logic [EXP_W-1:0]    exp_next;

	logic                div_start;
	logic [SUM_W-1:0]    div_dividend;
	logic [DIVR_W-1:0]   div_divisor;
	logic [SUM_W-1:0]    div_quo;
	logic                div_done;

	always_comb begin
		cfg_n = cfg_wr_data;
		if (cfg_wr_data == '0) begin
			cfg_n = PERIOD_W'(1);
		end else if (cfg_wr_data > PERIOD_W'(PERIOD_CAP)) begin
			cfg_n = PERIOD_W'(PERIOD_CAP);
		end
	end

	assign rd_ptr    = start_q ? '0 : ptr_q;
	assign full      = seen_q >= n_q;
	assign sum_next  = sum_q - (full ? SUM_W'(old_q) : '0) + SUM_W'(price_q);
	assign seen_next = full ? seen_q : seen_q + PERIOD_W'(1);
	assign ptr_inc   = CMP_W'(ptr_q) + CMP_W'(1);
	assign wrap      = ptr_inc >= CMP_W'(n_q);

	assign x   = {price_q, FRAC_W'(0)};
	assign q   = Q_W'(ph_q) + Q_W'(pl_q[PL_W-1:FRAC_W]);
	assign rem = pl_q[FRAC_W-1:0] != '0;

	always_comb begin
		if (start_q) begin
			exp_next = x;
		end else if (neg_q) begin
			exp_next = exp_q - EXP_W'(q) - EXP_W'(rem);
		end else begin
			exp_next = exp_q + EXP_W'(q);
		end
	end

	assign div_start    = cmd.wgt_start | cmd.ema;
	assign div_dividend = cmd.wgt_start ? SUM_W'(WEIGHT_NUM) : sum_q;
	assign div_divisor  = cmd.wgt_start ? ({1'b0, n_q} + DIVR_W'(1)) : {1'b0, n_q};

	sme_div #(
		.DIVD_W(SUM_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.start(div_start),
		.dividend(div_dividend),
		.divisor(div_divisor),
		.quotient(div_quo),
		.done(div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q     <= PERIOD_W'(RESET_PERIOD);
			w_q     <= WEIGHT_W'(RESET_WEIGHT);
			stale_q <= 1'b0;
			sum_q   <= '0;
			seen_q  <= '0;
			ptr_q   <= '0;
			exp_q   <= '0;
		end else if (cfg_wr_en) begin
			n_q     <= cfg_n;
			stale_q <= 1'b1;
			sum_q   <= '0;
			seen_q  <= '0;
			ptr_q   <= '0;
		end else begin
			if (cmd.wgt_load) begin
				w_q     <= div_quo[WEIGHT_W-1:0];
				stale_q <= 1'b0;
			end
			if (cmd.prep && start_q) begin
				sum_q  <= '0;
				seen_q <= '0;
				ptr_q  <= '0;
			end
			if (cmd.upd) begin
				sum_q  <= sum_next;
				seen_q <= seen_next;
				ptr_q  <= wrap ? '0 : ptr_inc[PTR_W-1:0];
			end
			if (cmd.ema) begin
				exp_q <= exp_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			old_q <= ring_mem[rd_ptr];
		end
		if (cmd.upd) begin
			ring_mem[ptr_q] <= price_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			price_q <= sample.price;
			start_q <= sample.series_start;
		end
		if (cmd.prep) begin
			if (x >= exp_q) begin
				d_q   <= x - exp_q;
				neg_q <= 1'b0;
			end else begin
				d_q   <= exp_q - x;
				neg_q <= 1'b1;
			end
		end
		if (cmd.upd) begin
			ph_q    <= PH_W'(d_q[EXP_W-1:FRAC_W]) * PH_W'(w_q);
			pl_q    <= PL_W'(d_q[FRAC_W-1:0]) * PL_W'(w_q);
			ready_q <= seen_next >= n_q;
		end
		if (cmd.out_load) begin
			result_q.window_mean <= ready_q ? div_quo[SAMPLE_W-1:0] : '0;
			result_q.mean_ready  <= ready_q;
			result_q.exp_mean    <= exp_q[EXP_W-1:FRAC_W];
		end
	end

	assign sts.wgt_stale = stale_q;
	assign sts.div_done  = div_done;
	assign result        = result_q;

`ifndef SYNTHESIS
	a_seen_bound: assert property (@(posedge clk) disable iff (!arst_n)
		seen_q <= n_q)
		else $error("sample count exceeds period");

	a_ptr_bound: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(ptr_q) < CMP_W'(n_q))
		else $error("ring pointer outside window");

	a_period_range: assert property (@(posedge clk) disable iff (!arst_n)
		n_q != '0 && n_q <= PERIOD_W'(PERIOD_CAP))
		else $error("period out of range");
`endif

endmodule

[sv/sme_ctrl.sv]
// ----------------------------------------------------------------------------
// sme_ctrl: moving average controller
// Sequences weight refresh, window update, EMA update, mean divide and output.
// ----------------------------------------------------------------------------
module sme_ctrl
	import sme_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     sample_valid,
	output logic     sample_ready,
	output logic     result_valid,
	input  logic     result_ready,
	input  sme_sts_t sts,
	output sme_cmd_t cmd
);

	sme_state_t state_q;
	sme_state_t state_d;
	logic       out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = sts.wgt_stale ? ST_WGT_GO : ST_PREP;
				end
			end
			ST_WGT_GO: begin
				cmd.wgt_start = 1'b1;
				state_d       = ST_WGT_WAIT;
			end
			ST_WGT_WAIT: begin
				if (sts.div_done) begin
					cmd.wgt_load = 1'b1;
					state_d      = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_UPD;
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_EMA;
			end
			ST_EMA: begin
				cmd.ema = 1'b1;
				state_d = ST_DIV_WAIT;
			end
			ST_DIV_WAIT: begin
				if (sts.div_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!out_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign result_valid = out_valid_q;

`ifndef SYNTHESIS
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		sts.div_done |-> (state_q == ST_WGT_WAIT || state_q == ST_DIV_WAIT))
		else $error("divider finished outside a wait state");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(sample_valid && sample_ready) |=> !sample_ready)
		else $error("second item taken while one is in flight");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> result_valid)
		else $error("loaded result not presented");
`endif

endmodule

[sv/simple_and_exponential_moving_average_core.sv]
// ----------------------------------------------------------------------------
// simple_and_exponential_moving_average_core: window mean and EMA of prices
// Each input item runs the prep, window update and EMA steps, then waits for the
// bit-serial divide for the mean before its result item is loaded. The first
// item after a period write first waits for the weight divide.
// One item is in flight; the next is taken while a result waits.
// Reset: asynchronous, clears window, EMA state and handshake; period 20.
// ----------------------------------------------------------------------------
module simple_and_exponential_moving_average_core
	import sme_pkg::*;
#(
	parameter int MAX_PERIOD = 256
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_wr_en,
	input  logic [PERIOD_W-1:0] cfg_wr_data,
	input  logic                sample_valid,
	output logic                sample_ready,
	input  sme_in_t             sample,
	output logic                result_valid,
	input  logic                result_ready,
	output sme_out_t            result
);

	sme_cmd_t cmd;
	sme_sts_t sts;

	sme_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.sts(sts),
		.cmd(cmd)
	);

	sme_dp #(
		.MAX_PERIOD(MAX_PERIOD)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.sample(sample),
		.cmd(cmd),
		.sts(sts),
		.result(result)
	);

endmodule

[bench/simple_and_exponential_moving_average_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// simple_and_exponential_moving_average_core_tb: window mean and EMA checks
// Streams price samples through the core under random idling on both sides
// and across several window periods. A behavioral copy of the window, the
// running sum and the EMA accumulator predicts every result item, and the
// results are compared field by field in order.
// ----------------------------------------------------------------------------
module simple_and_exponential_moving_average_core_tb;
	import sme_pkg::*;

	localparam int MAX_PERIOD  = 256;
	localparam int CLK_HALF    = 4;
	localparam int STALL_LIMIT = 4000;
	localparam int LONG_HOLD   = 300;
	localparam int SETTLE      = 100;
	localparam int PHASE_CNT   = 9;
	localparam int OPEN_CNT    = 14;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_wr_en = 1'b0;
	logic [PERIOD_W-1:0] cfg_wr_data = '0;
	logic                sample_valid = 1'b0;
	logic                sample_ready;
	sme_in_t             sample = '0;
	logic                result_valid;
	logic                result_ready = 1'b0;
	sme_out_t            result;

	sme_in_t  price_queue [$];
	sme_out_t expected_avgs [$];
	int       pushed_cnt = 0;
	int       checked_cnt = 0;
	int       mismatches = 0;
	int       quiet_cycles = 0;
	int       tx_wait = 0;
	int       rx_wait = 0;
	logic     in_fire = 1'b0;
	logic     out_fire = 1'b0;
	logic     gaps_on = 1'b1;
	logic     hold_req = 1'b0;

	logic [SAMPLE_W-1:0] ring_mem [MAX_PERIOD];
	logic [63:0]         run_sum = '0;
	int unsigned         seen_cnt = 0;
	int unsigned         ring_pos = 0;
	int unsigned         period_n = DEF_PERIOD;
	logic [EXP_W-1:0]    ema_acc = '0;
	logic [WEIGHT_W-1:0] ema_wgt = WEIGHT_W'(WEIGHT_NUM / (DEF_PERIOD + 1));

	int phase_period [PHASE_CNT] = '{0, 2, 256, 3, 511, 1, 7, 33, 20};

	logic [SAMPLE_W-1:0] open_price [OPEN_CNT] = '{
		32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'hAAAA_AAAA, 32'h5555_5555, 32'hFFFF_FFFF, 32'h0000_0000,
		32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF,
		32'h8000_0000, 32'h7FFF_FFFF
	};
	logic [OPEN_CNT-1:0] open_start = 14'b10_0100_0100_0000;

	simple_and_exponential_moving_average_core #(
		.MAX_PERIOD(MAX_PERIOD)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample      (sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

	always #(CLK_HALF) clk = ~clk;

	function automatic sme_out_t advance_averages(sme_in_t s);
		sme_out_t         r;
		logic [EXP_W-1:0] x;
		logic [EXP_W-1:0] d;
		logic [79:0]      prod;
		logic [63:0]      q;
		x = {s.price, {FRAC_W{1'b0}}};
		if (s.series_start) begin
			run_sum = '0;
			seen_cnt = 0;
			ring_pos = 0;
		end
		if (ring_pos >= period_n)
			ring_pos = 0;
		if (seen_cnt >= period_n)
			run_sum = run_sum - ring_mem[ring_pos];
		ring_mem[ring_pos] = s.price;
		run_sum = run_sum + s.price;
		ring_pos = (ring_pos + 1 >= period_n) ? 0 : ring_pos + 1;
		if (seen_cnt < period_n)
			seen_cnt++;
		if (s.series_start) begin
			ema_acc = x;
		end else if (x >= ema_acc) begin
			d = x - ema_acc;
			prod = d * ema_wgt;
			q = prod[79:16];
			ema_acc = ema_acc + q[EXP_W-1:0];
		end else begin
			d = ema_acc - x;
			prod = d * ema_wgt;
			q = prod[79:16] + (prod[15:0] != 0);
			ema_acc = ema_acc - q[EXP_W-1:0];
		end
		r.mean_ready = seen_cnt >= period_n;
		r.window_mean = r.mean_ready ? SAMPLE_W'(run_sum / 64'(period_n)) : '0;
		r.exp_mean = ema_acc[EXP_W-1:FRAC_W];
		return r;
	endfunction

	task automatic push_item(input logic [SAMPLE_W-1:0] p, input logic s);
		price_queue.push_back('{price: p, series_start: s});
		pushed_cnt++;
	endtask

	task automatic write_period(input int v);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_wr_data = v[PERIOD_W-1:0];
		period_n = (v == 0) ? 1 : (v > MAX_PERIOD) ? MAX_PERIOD : v;
		ema_wgt = WEIGHT_W'(WEIGHT_NUM / (period_n + 1));
		run_sum = '0;
		seen_cnt = 0;
		ring_pos = 0;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic wait_drained();
		while (checked_cnt != pushed_cnt)
			@(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	always @(negedge clk) begin
		if (!sample_valid || in_fire) begin
			if (tx_wait > 0) begin
				sample_valid <= 1'b0;
				tx_wait--;
			end else if (price_queue.size() > 0) begin
				sample <= price_queue.pop_front();
				sample_valid <= 1'b1;
				tx_wait = gaps_on ? $urandom_range(0, 4) : 0;
			end else begin
				sample_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (out_fire)
			rx_wait = gaps_on ? $urandom_range(0, 4) : 0;
		if (hold_req) begin
			rx_wait = LONG_HOLD;
			hold_req = 1'b0;
		end
		if (rx_wait > 0) begin
			result_ready <= 1'b0;
			rx_wait--;
		end else begin
			result_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if ($urandom_range(0, 399) == 0)
			gaps_on <= ~gaps_on;
	end

	always @(posedge clk) begin
		sme_out_t want;
		in_fire <= arst_n && sample_valid && sample_ready;
		out_fire <= arst_n && result_valid && result_ready;
		if (arst_n && result_valid && result_ready) begin
			checked_cnt++;
			if (expected_avgs.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result item %h", $time, result);
			end else begin
				want = expected_avgs.pop_front();
				if (result.window_mean !== want.window_mean) begin
					mismatches++;
					$display("%0t: window_mean expected %h got %h", $time,
						want.window_mean, result.window_mean);
				end
				if (result.mean_ready !== want.mean_ready) begin
					mismatches++;
					$display("%0t: mean_ready expected %b got %b", $time,
						want.mean_ready, result.mean_ready);
				end
				if (result.exp_mean !== want.exp_mean) begin
					mismatches++;
					$display("%0t: exp_mean expected %h got %h", $time,
						want.exp_mean, result.exp_mean);
				end
			end
		end
		if (arst_n && sample_valid && sample_ready)
			expected_avgs.push_back(advance_averages(sample));
	end

	always @(posedge clk) begin
		if ((sample_valid && sample_ready) || (result_valid && result_ready) || cfg_wr_en)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		int                  cnt;
		logic                s;
		logic [SAMPLE_W-1:0] p;
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);
		for (int i = 0; i < OPEN_CNT; i++)
			push_item(open_price[i], open_start[i]);
		for (int ph = -1; ph < PHASE_CNT; ph++) begin
			if (ph >= 0) begin
				write_period(phase_period[ph]);
				@(posedge clk);
			end
			cnt = (period_n >= MAX_PERIOD) ? 350 : 160;
			for (int i = 0; i < cnt; i++) begin
				case ($urandom_range(0, 3))
					0: p = 32'hFFFF_FFFF - $urandom_range(0, 255);
					1: p = $urandom_range(0, 255);
					2: p = $urandom & 32'h00FF_FFFF;
					default: p = $urandom;
				endcase
				s = (i == 0 && ph[0]) || ($urandom_range(0, 3 * period_n + 10) == 0);
				push_item(p, s);
			end
			if (ph == 1)
				hold_req = 1'b1;
			wait_drained();
		end
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

[files.f]
sv/sme_pkg.sv
sv/sme_div.sv
sv/sme_dp.sv
sv/sme_ctrl.sv
sv/simple_and_exponential_moving_average_core.sv
bench/simple_and_exponential_moving_average_core_tb.sv
